@@ rtl/fsc_pkg.sv @@
package fsc_pkg;

  localparam int NUM_CORNERS = 8;
  localparam int NUM_PLANES  = 6;
  // unit normals carry this many fraction bits (1.0 == 2**NRM_SHIFT)
  localparam int NRM_SHIFT   = 30;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_TEST  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD,
    OP_SCALE,
    OP_MUL,
    OP_CMAX,
    OP_NORM,
    OP_SQRT,
    OP_DIV,
    OP_WRP
  } op_t;

  typedef enum logic [1:0] {
    MS_CROSS,
    MS_SQ,
    MS_DOT,
    MS_TEST
  } msel_t;

  typedef struct packed {
    op_t        op;
    msel_t      msel;
    logic [2:0] pidx;
    logic [1:0] ci;
    logic [2:0] k;
    logic       first;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic ready;
  } sts_t;

  // corner triple (p1, p2, p3) of each plane, j selects the member
  function automatic logic [2:0] corner_of(input logic [2:0] p, input logic [1:0] j);
    logic [8:0] t;
    logic [2:0] r;
    unique case (p)
      3'd0: t = {3'd1, 3'd5, 3'd6};
      3'd1: t = {3'd7, 3'd4, 3'd0};
      3'd2: t = {3'd4, 3'd5, 3'd1};
      3'd3: t = {3'd2, 3'd6, 3'd7};
      3'd4: t = {3'd5, 3'd4, 3'd7};
      3'd5: t = {3'd0, 3'd1, 3'd2};
      default: t = '0;
    endcase
    unique case (j)
      2'd0: r = t[8:6];
      2'd1: r = t[5:3];
      default: r = t[2:0];
    endcase
    return r;
  endfunction

endpackage

@@ rtl/frustum_sphere_cull.sv @@
// Test: accepted when idle; the result strobe (done) follows 18 products through the one shared
//   multiplier and a short drain, and the next test is taken only once the block is idle again.
// Load: no result. Build: six planes, each dominated by the bit-per-cycle square root
//   and the three bit-per-cycle divides.
// Reset clears both corner and plane stores at once; the receiver cannot stall results.
module frustum_sphere_cull (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [2:0]         corner_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] radius,
  output logic               done,
  output logic               inside_res
);
  import fsc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic xfer;

  assign xfer = start && !busy;

  fsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  fsc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .xfer         (xfer),
    .action       (action),
    .corner_index (corner_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .radius       (radius),
    .cmd          (cmd),
    .sts          (sts),
    .sphere_in    (inside_res)
  );

endmodule

@@ rtl/fsc_mul.sv @@
module fsc_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  // register every product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ rtl/fsc_ctrl.sv @@
module fsc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    action,
  input  fsc_pkg::sts_t sts,
  output logic          busy,
  output logic          done,
  output fsc_pkg::cmd_t cmd
);
  import fsc_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_TMUL   = 17'h00002,
    S_TDRN   = 17'h00004,
    S_TOUT   = 17'h00008,
    S_BRD    = 17'h00010,
    S_BSCL   = 17'h00020,
    S_BXMUL  = 17'h00040,
    S_BXDRN  = 17'h00080,
    S_BMAX   = 17'h00100,
    S_BNRM   = 17'h00200,
    S_BSQM   = 17'h00400,
    S_BSQDRN = 17'h00800,
    S_BSQRT  = 17'h01000,
    S_BDIV   = 17'h02000,
    S_BDTM   = 17'h04000,
    S_BDTDRN = 17'h08000,
    S_BWR    = 17'h10000
  } state_t;

  state_t     state, state_next;
  logic [2:0] pidx, pidx_next;
  logic [1:0] ci, ci_next;
  logic [4:0] cnt, cnt_next;

  localparam logic [2:0] LAST_PLANE = 3'(NUM_PLANES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pidx  <= '0;
      ci    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pidx  <= pidx_next;
      ci    <= ci_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_TOUT);

  // sequence the tests and the per-plane build steps
  always_comb begin
    state_next = state;
    pidx_next  = pidx;
    ci_next    = ci;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.msel   = MS_CROSS;
    cmd.pidx   = pidx;
    cmd.ci     = ci;
    cmd.k      = {1'b0, ci};
    unique case (state)
      S_IDLE: begin
        pidx_next = '0;
        ci_next   = '0;
        cnt_next  = '0;
        if (start && action == ACT_TEST) begin
          state_next = S_TMUL;
        end else if (start && action == ACT_BUILD) begin
          state_next = S_BRD;
        end
      end
      S_TMUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_TEST;
        if (ci == 2'd2) begin
          ci_next = '0;
          if (pidx == LAST_PLANE) begin
            cnt_next   = '0;
            state_next = S_TDRN;
          end else begin
            pidx_next = pidx + 3'd1;
          end
        end else begin
          ci_next = ci + 2'd1;
        end
      end
      S_TDRN: begin
        if (cnt == 5'd1) begin
          state_next = S_TOUT;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_TOUT: begin
        state_next = S_IDLE;
      end
      S_BRD: begin
        cmd.op = OP_RD;
        if (ci == 2'd2) begin
          ci_next    = '0;
          state_next = S_BSCL;
        end else begin
          ci_next = ci + 2'd1;
        end
      end
      S_BSCL: begin
        cmd.op     = OP_SCALE;
        cnt_next   = '0;
        state_next = S_BXMUL;
      end
      S_BXMUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_CROSS;
        cmd.k    = cnt[2:0];
        if (cnt == 5'd5) begin
          state_next = S_BXDRN;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_BXDRN: begin
        state_next = S_BMAX;
      end
      S_BMAX: begin
        cmd.op     = OP_CMAX;
        state_next = S_BNRM;
      end
      S_BNRM: begin
        cmd.op = OP_NORM;
        if (sts.zero) begin
          ci_next = '0;
          if (pidx == LAST_PLANE) begin
            state_next = S_IDLE;
          end else begin
            pidx_next  = pidx + 3'd1;
            state_next = S_BRD;
          end
        end else if (sts.ready) begin
          ci_next    = '0;
          state_next = S_BSQM;
        end
      end
      S_BSQM: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_SQ;
        if (ci == 2'd2) begin
          ci_next    = '0;
          state_next = S_BSQDRN;
        end else begin
          ci_next = ci + 2'd1;
        end
      end
      S_BSQDRN: begin
        cnt_next   = '0;
        state_next = S_BSQRT;
      end
      S_BSQRT: begin
        cmd.op    = OP_SQRT;
        cmd.first = (cnt == 5'd0);
        if (cnt == 5'd31) begin
          cnt_next   = '0;
          ci_next    = '0;
          state_next = S_BDIV;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_BDIV: begin
        cmd.op    = OP_DIV;
        cmd.first = (cnt == 5'd0);
        cmd.last  = (cnt == 5'd30);
        if (cnt == 5'd30) begin
          cnt_next = '0;
          if (ci == 2'd2) begin
            ci_next    = '0;
            state_next = S_BDTM;
          end else begin
            ci_next = ci + 2'd1;
          end
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_BDTM: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_DOT;
        if (ci == 2'd2) begin
          ci_next    = '0;
          state_next = S_BDTDRN;
        end else begin
          ci_next = ci + 2'd1;
        end
      end
      S_BDTDRN: begin
        state_next = S_BWR;
      end
      S_BWR: begin
        cmd.op  = OP_WRP;
        ci_next = '0;
        if (pidx == LAST_PLANE) begin
          state_next = S_IDLE;
        end else begin
          pidx_next  = pidx + 3'd1;
          state_next = S_BRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/fsc_dp.sv @@
module fsc_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               xfer,
  input  logic [1:0]         action,
  input  logic [2:0]         corner_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] radius,
  input  fsc_pkg::cmd_t      cmd,
  output fsc_pkg::sts_t      sts,
  output logic               sphere_in
);
  import fsc_pkg::*;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // stores
  logic signed [31:0] corner  [NUM_CORNERS][3];
  logic signed [31:0] plane_n [NUM_PLANES][3];
  logic signed [31:0] plane_d [NUM_PLANES];

  // build working registers
  logic signed [31:0] p1 [3];
  logic signed [32:0] e  [6];
  logic signed [63:0] c  [3];
  logic signed [31:0] n  [3];
  logic [63:0]        m;
  logic [63:0]        sq;
  logic [63:0]        num, res, sbit;
  logic [31:0]        rem, q;
  logic signed [65:0] acc;

  // test registers
  logic signed [31:0] center [3];
  logic signed [31:0] rad;
  logic               dot_vld;
  logic signed [65:0] dot_val;
  logic [2:0]         dot_plane;

  // multiplier and its tags
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               t_vld;
  msel_t              t_sel;
  logic [2:0]         t_k;
  logic [2:0]         t_plane;

  fsc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // corner read for the current triple member
  logic [2:0]         rd_idx;
  logic signed [31:0] cv [3];
  assign rd_idx = corner_of(cmd.pidx, cmd.ci);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cv[i] = corner[rd_idx][i];
    end
  end

  // edge scaling amount
  logic [32:0] emax;
  logic [1:0]  esh;
  always_comb begin
    emax = '0;
    for (int i = 0; i < 6; i++) begin
      if (mag33(e[i]) > emax) begin
        emax = mag33(e[i]);
      end
    end
    priority if (emax[32]) esh = 2'd3;
    else if (emax[31])     esh = 2'd2;
    else if (emax[30])     esh = 2'd1;
    else                   esh = 2'd0;
  end

  // cross product magnitude
  logic [63:0] cmax;
  always_comb begin
    cmax = '0;
    for (int i = 0; i < 3; i++) begin
      if (mag64(c[i]) > cmax) begin
        cmax = mag64(c[i]);
      end
    end
  end

  logic m_hi, m_lo;
  assign m_hi      = |m[63:31];
  assign m_lo      = ~|m[63:30];
  assign sts.zero  = (m == 64'd0);
  assign sts.ready = !m_hi && !m_lo;

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.msel)
      MS_CROSS: begin
        unique case (cmd.k)
          3'd0: begin mul_a = e[1]; mul_b = e[5]; end
          3'd1: begin mul_a = e[2]; mul_b = e[4]; end
          3'd2: begin mul_a = e[2]; mul_b = e[3]; end
          3'd3: begin mul_a = e[0]; mul_b = e[5]; end
          3'd4: begin mul_a = e[0]; mul_b = e[4]; end
          default: begin mul_a = e[1]; mul_b = e[3]; end
        endcase
      end
      MS_SQ: begin
        mul_a = {1'b0, mag32(c[cmd.ci][31:0])};
        mul_b = {1'b0, mag32(c[cmd.ci][31:0])};
      end
      MS_DOT: begin
        mul_a = 33'(n[cmd.ci]);
        mul_b = 33'(p1[cmd.ci]);
      end
      default: begin
        mul_a = 33'(plane_n[cmd.pidx][cmd.ci]);
        mul_b = 33'(center[cmd.ci]);
      end
    endcase
  end

  // square root step
  logic [63:0] num_in, res_in, bit_in, trial;
  always_comb begin
    num_in = cmd.first ? sq : num;
    res_in = cmd.first ? 64'd0 : res;
    bit_in = cmd.first ? (64'd1 << 62) : sbit;
    trial  = res_in + bit_in;
  end

  // restoring divide step, quotient starts empty on the first step
  logic [31:0] len;
  logic [32:0] rem_in;
  logic        div_ge;
  logic [31:0] q_new;
  always_comb begin
    len    = res[31:0];
    rem_in = cmd.first ? {1'b0, mag32(c[cmd.ci][31:0])} : {rem, 1'b0};
    div_ge = (rem_in >= {1'b0, len});
    q_new  = cmd.first ? {31'd0, div_ge} : {q[30:0], div_ge};
  end

  // plane offset with saturation
  logic signed [65:0] neg_acc;
  logic signed [35:0] dsh;
  logic signed [31:0] d_sat;
  always_comb begin
    neg_acc = -acc;
    dsh     = neg_acc[65:30];
    if (dsh[35:31] == 5'b00000 || dsh[35:31] == 5'b11111) begin
      d_sat = dsh[31:0];
    end else if (!dsh[35]) begin
      d_sat = 32'sh7FFFFFFF;
    end else begin
      d_sat = 32'sh80000000;
    end
  end

  // accumulate arriving products
  logic signed [65:0] acc_new;
  assign acc_new = ((t_k == 3'd0) ? 66'sd0 : acc) + prod;

  // test distance against the radius
  logic signed [36:0] dist_sum, rad_x;
  always_comb begin
    dist_sum = {dot_val[65], dot_val[65:30]} +
               {{5{plane_d[dot_plane][31]}}, plane_d[dot_plane]};
    rad_x    = {{5{rad[31]}}, rad};
  end

  // stores and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        for (int j = 0; j < 3; j++) begin
          corner[i][j] <= '0;
        end
      end
      for (int i = 0; i < NUM_PLANES; i++) begin
        for (int j = 0; j < 3; j++) begin
          plane_n[i][j] <= '0;
        end
        plane_d[i] <= '0;
      end
      t_vld     <= 1'b0;
      dot_vld   <= 1'b0;
      sphere_in <= 1'b1;
    end else begin
      if (xfer && action == ACT_LOAD) begin
        corner[corner_index][0] <= pos_x;
        corner[corner_index][1] <= pos_y;
        corner[corner_index][2] <= pos_z;
      end
      if (cmd.op == OP_NORM && sts.zero) begin
        for (int j = 0; j < 3; j++) begin
          plane_n[cmd.pidx][j] <= '0;
        end
        plane_d[cmd.pidx] <= '0;
      end else if (cmd.op == OP_WRP) begin
        for (int j = 0; j < 3; j++) begin
          plane_n[cmd.pidx][j] <= n[j];
        end
        plane_d[cmd.pidx] <= d_sat;
      end
      t_vld   <= (cmd.op == OP_MUL);
      dot_vld <= t_vld && (t_sel == MS_TEST) && (t_k == 3'd2);
      if (xfer && action == ACT_TEST) begin
        sphere_in <= 1'b1;
      end else if (dot_vld && dist_sum > rad_x) begin
        sphere_in <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    t_sel   <= cmd.msel;
    t_k     <= cmd.k;
    t_plane <= cmd.pidx;
    dot_val <= acc_new;
    dot_plane <= t_plane;

    if (xfer && action == ACT_TEST) begin
      center[0] <= pos_x;
      center[1] <= pos_y;
      center[2] <= pos_z;
      rad       <= radius;
    end

    // load the triple and form the edges
    if (cmd.op == OP_RD) begin
      for (int i = 0; i < 3; i++) begin
        unique case (cmd.ci)
          2'd0: p1[i] <= cv[i];
          2'd1: e[i] <= 33'(p1[i]) - 33'(cv[i]);
          default: e[i + 3] <= 33'(p1[i]) - 33'(cv[i]);
        endcase
      end
    end

    if (cmd.op == OP_SCALE) begin
      for (int i = 0; i < 6; i++) begin
        e[i] <= e[i] >>> esh;
      end
    end

    if (cmd.op == OP_CMAX) begin
      m <= cmax;
    end

    // normalize the cross product one bit at a time
    if (cmd.op == OP_NORM && !sts.zero) begin
      if (m_hi) begin
        for (int i = 0; i < 3; i++) begin
          c[i] <= c[i] >>> 1;
        end
        m <= m >> 1;
      end else if (m_lo) begin
        for (int i = 0; i < 3; i++) begin
          c[i] <= c[i] <<< 1;
        end
        m <= m << 1;
      end
    end

    // take products
    if (t_vld) begin
      unique case (t_sel)
        MS_CROSS: begin
          if (t_k[0]) begin
            c[t_k[2:1]] <= c[t_k[2:1]] - prod[63:0];
          end else begin
            c[t_k[2:1]] <= prod[63:0];
          end
        end
        MS_SQ: begin
          sq <= ((t_k == 3'd0) ? 64'd0 : sq) + prod[63:0];
        end
        default: begin
          acc <= acc_new;
        end
      endcase
    end

    if (cmd.op == OP_SQRT) begin
      if (num_in >= trial) begin
        num <= num_in - trial;
        res <= (res_in >> 1) + bit_in;
      end else begin
        num <= num_in;
        res <= res_in >> 1;
      end
      sbit <= bit_in >> 2;
    end

    if (cmd.op == OP_DIV) begin
      rem <= div_ge ? 32'(rem_in - {1'b0, len}) : rem_in[31:0];
      q   <= q_new;
      if (cmd.last) begin
        n[cmd.ci] <= c[cmd.ci][63] ? -$signed(q_new) : $signed(q_new);
      end
    end
  end

endmodule

@@ tb/frustum_sphere_cull_checker.sv @@
module frustum_sphere_cull_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         action,
  input  logic [2:0]         corner_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] radius,
  input  logic               done,
  input  logic               inside_res,
  output int                 fail_count,
  output int                 verdicts_pending
);
  import fsc_pkg::*;

  // shadow copy of the corner and plane stores
  logic signed [31:0] corner_xyz [NUM_CORNERS][3];
  logic signed [31:0] plane_abcd [NUM_PLANES][4];
  logic               inside_q [$];

  assign verdicts_pending = inside_q.size();

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned num);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > num) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num = num - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // derive one plane from its corner triple
  task automatic derive_plane(input int p);
    longint e [6];
    longint cr [3];
    longint unsigned m, sq, len;
    longint n, dot;
    int sh, i;
    logic [2:0] k1, k2, k3;
    k1 = corner_of(3'(p), 2'd0);
    k2 = corner_of(3'(p), 2'd1);
    k3 = corner_of(3'(p), 2'd2);
    for (i = 0; i < 3; i++) begin
      e[i]   = longint'(corner_xyz[k1][i]) - longint'(corner_xyz[k2][i]);
      e[i+3] = longint'(corner_xyz[k1][i]) - longint'(corner_xyz[k3][i]);
    end
    // bring every edge magnitude below 2^30
    m = 0;
    for (i = 0; i < 6; i++) if (magnitude(e[i]) > m) m = magnitude(e[i]);
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    for (i = 0; i < 6; i++) e[i] = e[i] >>> sh;
    cr[0] = e[1] * e[5] - e[2] * e[4];
    cr[1] = e[2] * e[3] - e[0] * e[5];
    cr[2] = e[0] * e[4] - e[1] * e[3];
    m = 0;
    for (i = 0; i < 3; i++) if (magnitude(cr[i]) > m) m = magnitude(cr[i]);
    if (m == 0) begin
      for (i = 0; i < 4; i++) plane_abcd[p][i] = '0;
      return;
    end
    // normalize the largest component into [2^30, 2^31)
    sh = 0;
    if (m >= (64'd1 << 31)) begin
      while ((m >> sh) >= (64'd1 << 31)) sh++;
      for (i = 0; i < 3; i++) cr[i] = cr[i] >>> sh;
    end else begin
      while ((m << sh) < (64'd1 << 30)) sh++;
      for (i = 0; i < 3; i++) cr[i] = cr[i] <<< sh;
    end
    sq = 0;
    for (i = 0; i < 3; i++) sq += magnitude(cr[i]) * magnitude(cr[i]);
    len = int_sqrt(sq);
    dot = 0;
    for (i = 0; i < 3; i++) begin
      n = (cr[i] <<< NRM_SHIFT) / longint'(len);
      plane_abcd[p][i] = n[31:0];
      dot += longint'(plane_abcd[p][i]) * longint'(corner_xyz[k1][i]);
    end
    plane_abcd[p][3] = clamp32((-dot) >>> NRM_SHIFT);
  endtask

  function automatic logic sphere_inside(input logic signed [31:0] x, y, z, r);
    longint dot, dist_sum;
    for (int p = 0; p < NUM_PLANES; p++) begin
      dot = longint'(plane_abcd[p][0]) * x + longint'(plane_abcd[p][1]) * y
          + longint'(plane_abcd[p][2]) * z;
      dist_sum = (dot >>> NRM_SHIFT) + longint'(plane_abcd[p][3]);
      if (dist_sum > longint'(r)) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CORNERS; i++)
        for (int j = 0; j < 3; j++) corner_xyz[i][j] = '0;
      for (int i = 0; i < NUM_PLANES; i++)
        for (int j = 0; j < 4; j++) plane_abcd[i][j] = '0;
      inside_q.delete();
      fail_count = 0;
    end else begin
      // compare a result strobe with the oldest verdict
      if (done) begin
        if (inside_q.size() == 0) begin
          $error("inside_res: unexpected result %0b", inside_res);
          fail_count++;
        end else begin
          logic want;
          want = inside_q.pop_front();
          if (inside_res !== want) begin
            $error("inside_res: expected %0b, got %0b", want, inside_res);
            fail_count++;
          end
        end
      end
      // advance the shadow state on each accepted transfer
      if (start && !busy) begin
        case (action)
          ACT_LOAD: begin
            corner_xyz[corner_index][0] = pos_x;
            corner_xyz[corner_index][1] = pos_y;
            corner_xyz[corner_index][2] = pos_z;
          end
          ACT_BUILD: for (int p = 0; p < NUM_PLANES; p++) derive_plane(p);
          ACT_TEST: inside_q.push_back(sphere_inside(pos_x, pos_y, pos_z, radius));
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/tb_frustum_sphere_cull.sv @@
module tb_frustum_sphere_cull;
  import fsc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action = ACT_LOAD;
  logic [2:0]         corner_index = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic signed [31:0] radius = '0;
  logic               done;
  logic               inside_res;
  int                 fail_count;
  int                 verdicts_pending;
  int                 burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frustum_sphere_cull DUT (.*);

  frustum_sphere_cull_checker u_checker (.*);

  // one transfer; gaps fall between bursts of random length
  task automatic issue(input logic [1:0] a, input logic [2:0] ci,
                       input logic [31:0] x, y, z, r);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    action = a;
    corner_index = ci;
    pos_x = x;
    pos_y = y;
    pos_z = z;
    radius = r;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    burst_left--;
  endtask

  // load a plausible frustum: near and far rectangles on the z axis
  task automatic load_frustum();
    int unsigned wn, hn, wf, hf, zn, zf;
    int sx, sy;
    wn = $urandom_range(1, 1 << 20);
    hn = $urandom_range(1, 1 << 20);
    wf = wn + $urandom_range(0, 1 << 24);
    hf = hn + $urandom_range(0, 1 << 24);
    zn = $urandom_range(1 << 10, 1 << 20);
    zf = zn + $urandom_range(1, 1 << 26);
    for (int k = 0; k < 8; k++) begin
      sx = k[0] ? 1 : -1;
      sy = k[1] ? 1 : -1;
      if (k < 4)
        issue(ACT_LOAD, 3'(k), sx * int'(wn), sy * int'(hn), -int'(zn), $urandom);
      else
        issue(ACT_LOAD, 3'(k), sx * int'(wf), sy * int'(hf), -int'(zf), $urandom);
    end
  endtask

  function automatic logic [31:0] spread();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 27) - (1 << 26);
      2: return $urandom_range(0, 1 << 22) - (1 << 21);
      default: return $urandom_range(0, 64) - 32;
    endcase
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // zero planes after reset: pass only when radius is not negative
    issue(ACT_TEST, 3'd7, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
    issue(ACT_TEST, 3'd0, 32'h0, 32'h0, 32'h0, 32'hffffffff);
    issue(ACT_TEST, 3'd0, 32'h1, 32'h1, 32'h1, 32'h80000000);
    issue(ACT_TEST, 3'd0, 32'h1, 32'h1, 32'h1, 32'h7fffffff);
    // unused action: no result, state unchanged
    issue(ACT_UNUSED, 3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    // degenerate triples: all corners equal
    issue(ACT_BUILD, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(ACT_TEST, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    // extreme corners, offsets saturate
    for (int k = 0; k < 8; k++)
      issue(ACT_LOAD, 3'(k), k[0] ? 32'h7fffffff : 32'h80000000,
            k[1] ? 32'h7fffffff : 32'h80000000,
            k[2] ? 32'h80000000 : 32'h7fffffff, 32'h0);
    issue(ACT_BUILD, 3'd7, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(ACT_TEST, 3'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0);
    issue(ACT_TEST, 3'd0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    issue(ACT_TEST, 3'd0, 32'h0, 32'h0, 32'h0, 32'h80000000);

    // random frames: corners, build, tests, with some noise
    for (int f = 0; f < 34; f++) begin
      if ($urandom_range(0, 5) == 0) begin
        for (int k = 0; k < 8; k++)
          issue(ACT_LOAD, 3'(k), $urandom, $urandom, $urandom, $urandom);
      end else begin
        load_frustum();
      end
      if ($urandom_range(0, 3) == 0)
        issue(ACT_LOAD, 3'($urandom), spread(), spread(), spread(), $urandom);
      issue(ACT_BUILD, 3'($urandom), $urandom, $urandom, $urandom, $urandom);
      repeat ($urandom_range(18, 28)) begin
        case ($urandom_range(0, 19))
          0: issue(ACT_UNUSED, 3'($urandom), $urandom, $urandom, $urandom, $urandom);
          1: issue(ACT_TEST, 3'($urandom), $urandom, $urandom, $urandom, $urandom);
          default: issue(ACT_TEST, 3'($urandom), spread(), spread(), spread(),
                         $urandom_range(0, 1) ? spread() : $urandom_range(0, 1 << 22));
        endcase
      end
    end
    start = 1'b0;

    wait (verdicts_pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 2000000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
